// File: sv/pws_pkg.sv
// Shared types and constants for the polyline window smoother.
`default_nettype none
package pws_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned PASS_COUNT_DEF = 10;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned GAIN_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd32768;

  // window: center plus WIN_HALF on each side
  localparam int unsigned WIN_HALF = 4;
  localparam int unsigned WIN_LEN = 2 * WIN_HALF + 1;

  // sum of up to nine coordinates, its magnitude, and the window count
  localparam int unsigned SUM_W = 36;
  localparam int unsigned MAG_W = 35;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned BLEND_STAGES = 3;

  // stages between the last store cell and the first one:
  // window taps up to the center, the setup stage, divider, blend
  localparam int unsigned LOOP_EXTRA = WIN_HALF + 1 + 1 + DIV_STEPS + BLEND_STAGES;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_point;
  } pws_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      out_last;
    logic                      overflow;
  } pws_out_t;

  // one point traveling through the divider chain
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic [MAG_W-1:0]          wx;
    logic [MAG_W-1:0]          wy;
    logic [CNT_W-1:0]          rx;
    logic [CNT_W-1:0]          ry;
    logic                      nx;
    logic                      ny;
    logic [CNT_W-1:0]          cnt;
    logic                      upd;
  } pws_slot_t;

endpackage
`default_nettype wire

// File: sv/pws_div_cell.sv
// One restoring division step on both coordinates, carrying the point along.
`default_nettype none
module pws_div_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  pws_pkg::pws_slot_t slot_i,
  output pws_pkg::pws_slot_t slot_o
);
  import pws_pkg::*;

  logic [CNT_W:0] tx, ty, dv;
  logic           gex, gey;
  pws_slot_t      slot_d, slot_q;

  always_comb begin
    dv  = {1'b0, slot_i.cnt};
    tx  = {slot_i.rx, slot_i.wx[MAG_W-1]};
    ty  = {slot_i.ry, slot_i.wy[MAG_W-1]};
    gex = (tx >= dv);
    gey = (ty >= dv);
    slot_d    = slot_i;
    slot_d.wx = {slot_i.wx[MAG_W-2:0], gex};
    slot_d.wy = {slot_i.wy[MAG_W-2:0], gey};
    slot_d.rx = gex ? CNT_W'(tx - dv) : tx[CNT_W-1:0];
    slot_d.ry = gey ? CNT_W'(ty - dv) : ty[CNT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// File: sv/pws_blend.sv
// Three-stage blend of one coordinate toward its window average, saturated.
`default_nettype none
module pws_blend (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [pws_pkg::GAIN_W-1:0]           gain_i,
  input  logic signed [pws_pkg::COORD_W-1:0]   s_i,
  input  logic [pws_pkg::MAG_W-1:0]            quot_i,
  input  logic                                 neg_i,
  input  logic                                 upd_i,
  output logic signed [pws_pkg::COORD_W-1:0]   res_o
);
  import pws_pkg::*;

  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = DIFF_W + GAIN_W + 1;
  localparam int unsigned SH_W = PROD_W - 16;
  localparam int unsigned RES_W = SH_W + 1;

  logic signed [DIFF_W-1:0]  avg, diff_d;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [COORD_W-1:0] s_c_q, s_d_q, res_q;
  logic                      upd_c_q, upd_d_q;
  logic signed [SH_W-1:0]    sh;
  logic signed [RES_W-1:0]   sum;
  logic signed [COORD_W-1:0] sat;

  always_comb begin
    avg    = neg_i ? -$signed(quot_i[DIFF_W-1:0]) : $signed(quot_i[DIFF_W-1:0]);
    diff_d = avg - DIFF_W'(s_i);
    sh     = prod_q[PROD_W-1:16];
    sum    = RES_W'(sh) + RES_W'(s_d_q);
    if (sum > RES_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      sat = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sum < -RES_W'(signed'({1'b0, 1'b1, {(COORD_W-1){1'b0}}}))) begin
      sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat = sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= diff_d;
      s_c_q   <= s_i;
      upd_c_q <= upd_i;
      prod_q  <= diff_q * $signed({1'b0, gain_i});
      s_d_q   <= s_c_q;
      upd_d_q <= upd_c_q;
      res_q   <= upd_d_q ? sat : s_d_q;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// File: sv/polyline_window_smoother_top.sv
// Polyline window smoother: store ring, sliding window, divider and blend chain.
// Sequence: n words load at one per cycle, the ring is aligned, PASS_COUNT laps of the
// loop run, then the n words leave one per cycle while the output is not stalled.
// One line at a time: no new line is taken until the last has left. The loop (store
// cells, window, 35-step divider, blend) sets the lap time.
// Reset: async active low; clears control, counters, window sums; gain = 0.5.
`default_nettype none
module polyline_window_smoother_top #(
  parameter int unsigned MAX_POINTS = pws_pkg::MAX_POINTS_DEF,
  parameter int unsigned PASS_COUNT = pws_pkg::PASS_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pws_pkg::pws_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pws_pkg::pws_out_t          out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pws_pkg::GAIN_W-1:0] cfg_data_i
);
  import pws_pkg::*;

  localparam int unsigned LoopLen = MAX_POINTS + LOOP_EXTRA;
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW = $clog2(LoopLen);
  localparam int unsigned PW = $clog2(PASS_COUNT + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ALIGN,
    ST_PASS,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [NW-1:0]   n_q, emit_q;
  logic            drop_q;
  logic [SW-1:0]   step_q;
  logic [PW-1:0]   pass_q;
  logic            out_valid_q;
  pws_out_t        out_q;
  logic [GAIN_W-1:0] gain_q;

  // store ring: the line circulates ring -> window -> divider -> blend -> ring
  logic signed [COORD_W-1:0] ring_x_q [MAX_POINTS];
  logic signed [COORD_W-1:0] ring_y_q [MAX_POINTS];
  logic signed [COORD_W-1:0] tap_x, tap_y, inj_x, inj_y;
  logic signed [COORD_W-1:0] blend_x, blend_y;

  // sliding window, index 0 newest; WIN_HALF is the center point
  logic signed [COORD_W-1:0] win_x_q [WIN_LEN];
  logic signed [COORD_W-1:0] win_y_q [WIN_LEN];
  logic [WIN_LEN-1:0]        win_v_q, win_i_q;
  logic signed [SUM_W-1:0]   sum_x_q, sum_y_q, sum_x_d, sum_y_d;

  pws_slot_t slot_q;
  pws_slot_t chain [DIV_STEPS+1];

  logic store, load_acc, align_done, out_free, emit_shift, shift_en;
  logic tap_v, tap_int;
  logic [NW-1:0] align_gap;

  assign tap_x = ring_x_q[MAX_POINTS-1];
  assign tap_y = ring_y_q[MAX_POINTS-1];

  assign load_acc   = (state_q == ST_LOAD) && in_valid_i;
  assign store      = load_acc && (n_q < NW'(MAX_POINTS));
  assign align_gap  = NW'(MAX_POINTS) - n_q;
  assign align_done = (step_q == SW'(align_gap));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_shift = (state_q == ST_EMIT) && (emit_q != n_q) && out_free;
  assign shift_en   = store || ((state_q == ST_ALIGN) && !align_done) ||
                      (state_q == ST_PASS) || emit_shift;

  // tags for the point entering the window: in range, and interior
  assign tap_v   = (state_q == ST_PASS) && (step_q < SW'(n_q));
  assign tap_int = (state_q == ST_PASS) && (step_q != '0) &&
                   ((SW+1)'(step_q) + 1'b1 < (SW+1)'(n_q));

  // loading writes the new point where the blend output would re-enter
  assign inj_x = (state_q == ST_LOAD) ? in_data_i.x_coord : blend_x;
  assign inj_y = (state_q == ST_LOAD) ? in_data_i.y_coord : blend_y;

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      ring_x_q[0] <= inj_x;
      ring_y_q[0] <= inj_y;
      for (int k = 1; k < MAX_POINTS; k++) begin
        ring_x_q[k] <= ring_x_q[k-1];
        ring_y_q[k] <= ring_y_q[k-1];
      end
      win_x_q[0] <= tap_x;
      win_y_q[0] <= tap_y;
      for (int k = 1; k < WIN_LEN; k++) begin
        win_x_q[k] <= win_x_q[k-1];
        win_y_q[k] <= win_y_q[k-1];
      end
    end
  end

  // running window sums: add the entering point, drop the leaving one
  always_comb begin
    sum_x_d = sum_x_q + (tap_v ? SUM_W'(tap_x) : '0) -
              (win_v_q[WIN_LEN-1] ? SUM_W'(win_x_q[WIN_LEN-1]) : '0);
    sum_y_d = sum_y_q + (tap_v ? SUM_W'(tap_y) : '0) -
              (win_v_q[WIN_LEN-1] ? SUM_W'(win_y_q[WIN_LEN-1]) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_v_q <= '0;
      win_i_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (shift_en) begin
      win_v_q <= {win_v_q[WIN_LEN-2:0], tap_v};
      win_i_q <= {win_i_q[WIN_LEN-2:0], tap_int};
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

  // setup stage: center value, sum magnitudes and signs, window count
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      slot_q.sx  <= win_x_q[WIN_HALF];
      slot_q.sy  <= win_y_q[WIN_HALF];
      slot_q.wx  <= MAG_W'(sum_x_q[SUM_W-1] ? -sum_x_q : sum_x_q);
      slot_q.wy  <= MAG_W'(sum_y_q[SUM_W-1] ? -sum_y_q : sum_y_q);
      slot_q.nx  <= sum_x_q[SUM_W-1];
      slot_q.ny  <= sum_y_q[SUM_W-1];
      slot_q.rx  <= '0;
      slot_q.ry  <= '0;
      slot_q.cnt <= CNT_W'($countones(win_v_q));
      slot_q.upd <= win_i_q[WIN_HALF];
    end
  end

  assign chain[0] = slot_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    pws_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (shift_en),
      .slot_i (chain[g]),
      .slot_o (chain[g+1])
    );
  end

  pws_blend u_blend_x (
    .clk_i  (clk_i),
    .en_i   (shift_en),
    .gain_i (gain_q),
    .s_i    (chain[DIV_STEPS].sx),
    .quot_i (chain[DIV_STEPS].wx),
    .neg_i  (chain[DIV_STEPS].nx),
    .upd_i  (chain[DIV_STEPS].upd),
    .res_o  (blend_x)
  );

  pws_blend u_blend_y (
    .clk_i  (clk_i),
    .en_i   (shift_en),
    .gain_i (gain_q),
    .s_i    (chain[DIV_STEPS].sy),
    .quot_i (chain[DIV_STEPS].wy),
    .neg_i  (chain[DIV_STEPS].ny),
    .upd_i  (chain[DIV_STEPS].upd),
    .res_o  (blend_y)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      n_q         <= '0;
      drop_q      <= 1'b0;
      step_q      <= '0;
      pass_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= GAIN_RESET;
    end else begin
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      if (emit_shift) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (load_acc) begin
            if (store) begin
              n_q <= n_q + 1'b1;
            end else begin
              drop_q <= 1'b1;
            end
            if (in_data_i.last_point) begin
              state_q <= ST_ALIGN;
              step_q  <= '0;
            end
          end
        end
        ST_ALIGN: begin
          if (align_done) begin
            state_q <= ST_PASS;
            step_q  <= '0;
            pass_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_PASS: begin
          if (step_q == SW'(LoopLen - 1)) begin
            step_q <= '0;
            if (pass_q == PW'(PASS_COUNT - 1)) begin
              state_q <= ST_EMIT;
              emit_q  <= '0;
            end else begin
              pass_q <= pass_q + 1'b1;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_shift) begin
            emit_q <= emit_q + 1'b1;
          end else if ((emit_q == n_q) && out_free) begin
            state_q <= ST_LOAD;
            n_q     <= '0;
            drop_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_shift) begin
      out_q.out_x    <= tap_x;
      out_q.out_y    <= tap_y;
      out_q.out_last <= (emit_q == NW'(n_q - 1'b1));
      out_q.overflow <= drop_q;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef ASSERT_OFF
  a_no_out_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("output word pending while loading");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(MAX_POINTS))
    else $error("point count above capacity");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.out_last) |=> !in_stall_o)
    else $error("input not reopened after final word");
`endif

endmodule
`default_nettype wire
